// ===== design/pair_sum_match_search_top_defines.svh =====
// ----------------------------------------------------------------------------
// Pair sum match search assertion macros
// Shared property forms for the checker of the pair sum match search block.
// ----------------------------------------------------------------------------
`ifndef PAIR_SUM_MATCH_SEARCH_TOP_DEFINES_SVH
`define PAIR_SUM_MATCH_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pair sum match search: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pair sum match search: next-cycle property failed");

`endif

// ===== design/psms_pkg.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search package
// Shared constants, the controller state type and the command and status words.
// ----------------------------------------------------------------------------
package psms_pkg;

	// Default sizes of the value table and the stored fields.
	localparam int DEF_TABLE_DEPTH   = 256;
	localparam int DEF_VALUE_BITS    = 32;
	localparam int DEF_POSITION_BITS = 16;

	// Fixed field widths on the ports.
	localparam int IN_VALUE_BITS = 32;
	localparam int TARGET_BITS   = 33;
	localparam int OUT_POS_BITS  = 16;
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 4;

	// Register index, taken from the 8-byte slot bit of the address.
	localparam logic REG_TARGET_SUM = 1'b0;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} psms_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic scan_rd;
		logic commit;
	} psms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pair_done;
		logic table_empty;
		logic scan_last;
		logic result_needed;
		logic out_free;
	} psms_status_t;

endpackage

// ===== design/psms_if.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface psms_in_if;
	import psms_pkg::*;

	logic                            valid;
	logic                            ready;
	logic signed [IN_VALUE_BITS-1:0] value;
	logic                            last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink (input valid, input value, input last_item, output ready);
endinterface

interface psms_out_if;
	import psms_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [OUT_POS_BITS-1:0] first_position;
	logic [OUT_POS_BITS-1:0] second_position;
	logic                    table_overflowed;

	modport source (output valid, output found, output first_position,
		output second_position, output table_overflowed, input ready);
	modport sink (input valid, input found, input first_position,
		input second_position, input table_overflowed, output ready);
endinterface

// ===== design/pair_sum_match_search_top.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search
// Two-sum search over a set of signed values with a value/position table.
// ----------------------------------------------------------------------------
// Each input word carries one value of a set; the block looks for an earlier
// value equal to target_sum minus this one and reports the first pair found,
// or a not-found word on the last value of the set, then clears for the next
// set. A word is accepted, the distinct values now held in the table are read
// one entry at a time on the single read port of the table memory, the
// registered read is drained and the word is decided; the decision waits while
// a result is due and the output register is still full. With an empty table,
// or after a pair has been found, a word goes straight from accept to decide.
// A finished result waits in an output register while the next word is taken.
// target_sum is written over the APB port at byte address 0 (64-bit data,
// low 33 bits used) and may only change while the block is idle.
module pair_sum_match_search_top #(
	parameter int TABLE_DEPTH   = psms_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS    = psms_pkg::DEF_VALUE_BITS,
	parameter int POSITION_BITS = psms_pkg::DEF_POSITION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	psms_in_if.sink                              in_ch,
	psms_out_if.source                           out_ch,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [psms_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [psms_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [psms_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import psms_pkg::*;

	logic [TARGET_BITS-1:0] target_sum_q;
	logic                   reg_sel;
	psms_cmd_t              cmd;
	psms_status_t           status;

	// Register decode on the 8-byte slot bit.
	assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_TARGET_SUM);
	assign pready  = 1'b1;

	// Target sum register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_sum_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			target_sum_q <= pwdata[TARGET_BITS-1:0];
		end
	end

	// Read back, sign extended to the bus width.
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(APB_DATA_BITS-TARGET_BITS){target_sum_q[TARGET_BITS-1]}},
				target_sum_q};
		end
	end

	psms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	psms_dp #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.VALUE_BITS    (VALUE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.value_in       (in_ch.value),
		.last_in        (in_ch.last_item),
		.target_sum     (target_sum_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_found      (out_ch.found),
		.out_first      (out_ch.first_position),
		.out_second     (out_ch.second_position),
		.out_overflowed (out_ch.table_overflowed)
	);

endmodule

// ===== design/psms_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search controller
// Sequences accept, table scan, read drain and the final decision per word.
// ----------------------------------------------------------------------------
module psms_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  psms_pkg::psms_status_t status,
	output psms_pkg::psms_cmd_t    cmd
);
	import psms_pkg::*;

	psms_state_t state_q;
	psms_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next  = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (status.pair_done || status.table_empty) begin
						state_next = ST_DECIDE;
					end else begin
						state_next = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!status.result_needed || status.out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/psms_dp.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search datapath
// Value table memory, scan compare, set bookkeeping and the result register.
// ----------------------------------------------------------------------------
module psms_dp #(
	parameter int TABLE_DEPTH   = psms_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS    = psms_pkg::DEF_VALUE_BITS,
	parameter int POSITION_BITS = psms_pkg::DEF_POSITION_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  psms_pkg::psms_cmd_t                     cmd,
	output psms_pkg::psms_status_t                  status,
	input  logic [psms_pkg::IN_VALUE_BITS-1:0]      value_in,
	input  logic                                    last_in,
	input  logic [psms_pkg::TARGET_BITS-1:0]        target_sum,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    out_found,
	output logic [psms_pkg::OUT_POS_BITS-1:0]       out_first,
	output logic [psms_pkg::OUT_POS_BITS-1:0]       out_second,
	output logic                                    out_overflowed
);
	import psms_pkg::*;

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int CW   = ((VALUE_BITS > TARGET_BITS) ? VALUE_BITS : TARGET_BITS) + 1;
	localparam int EW   = VALUE_BITS + POSITION_BITS;

	// Table memory: value in the upper bits, position in the lower bits.
	logic [EW-1:0] mem [TABLE_DEPTH];

	// Current word.
	logic [VALUE_BITS-1:0]    value_q;
	logic                     last_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [VALUE_BITS-1:0]    comp_q;
	logic                     comp_ok_q;

	// Set state.
	logic [POSITION_BITS-1:0] item_cnt_q;
	logic [CNTW-1:0]          count_q;
	logic                     pair_done_q;
	logic                     ovf_q;

	// Scan.
	logic [AW-1:0]            scan_addr_q;
	logic                     rd_valid_s1;
	logic [AW-1:0]            rd_idx_s1;
	logic [EW-1:0]            rd_entry_s1;
	logic                     hit_comp_q;
	logic [POSITION_BITS-1:0] comp_pos_q;
	logic                     hit_val_q;
	logic [AW-1:0]            val_idx_q;

	// Result register.
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [OUT_POS_BITS-1:0] out_first_q;
	logic [OUT_POS_BITS-1:0] out_second_q;
	logic                    out_ovf_q;

	// Combinational helpers.
	logic [VALUE_BITS+IN_VALUE_BITS-1:0] v_ext;
	logic [VALUE_BITS-1:0]               v_new;
	logic [CW+TARGET_BITS-1:0]           t_ext;
	logic [CW+VALUE_BITS-1:0]            v_wide;
	logic [CW-1:0]                       comp_full;
	logic [CW-VALUE_BITS:0]              comp_top;
	logic                                comp_ok;
	logic [POSITION_BITS-1:0]            cnt_inc;
	logic [VALUE_BITS-1:0]               rd_value;
	logic [POSITION_BITS-1:0]            rd_pos;
	logic                                table_full;
	logic                                ovf_next;
	logic                                mem_we;
	logic [AW-1:0]                       mem_waddr;
	logic                                load_out;
	logic [POSITION_BITS+OUT_POS_BITS-1:0] first_ext;
	logic [POSITION_BITS+OUT_POS_BITS-1:0] second_ext;

	// Input value resized to the table width, complement and its range check.
	always_comb begin
		v_ext     = {{VALUE_BITS{value_in[IN_VALUE_BITS-1]}}, value_in};
		v_new     = v_ext[VALUE_BITS-1:0];
		t_ext     = {{CW{target_sum[TARGET_BITS-1]}}, target_sum};
		v_wide    = {{CW{v_new[VALUE_BITS-1]}}, v_new};
		comp_full = t_ext[CW-1:0] - v_wide[CW-1:0];
		comp_top  = comp_full[CW-1:VALUE_BITS-1];
		comp_ok   = (&comp_top) || !(|comp_top);
		cnt_inc   = (item_cnt_q == '1) ? item_cnt_q : item_cnt_q + POSITION_BITS'(1);
	end

	// Table bookkeeping for the decision cycle.
	always_comb begin
		rd_value   = rd_entry_s1[EW-1:POSITION_BITS];
		rd_pos     = rd_entry_s1[POSITION_BITS-1:0];
		table_full = (count_q == CNTW'(TABLE_DEPTH));
		ovf_next   = ovf_q || (!hit_val_q && table_full);
		mem_we     = cmd.commit && !pair_done_q && !hit_comp_q && (hit_val_q || !table_full);
		mem_waddr  = hit_val_q ? val_idx_q : count_q[AW-1:0];
		load_out   = cmd.commit && status.result_needed;
		first_ext  = {{OUT_POS_BITS{1'b0}}, comp_pos_q};
		second_ext = {{OUT_POS_BITS{1'b0}}, pos_q};
	end

	// Status back to the controller.
	always_comb begin
		status.pair_done     = pair_done_q;
		status.table_empty   = (count_q == '0);
		status.scan_last     = ((CNTW'(scan_addr_q) + CNTW'(1)) == count_q);
		status.result_needed = !pair_done_q && (hit_comp_q || last_q);
		status.out_free      = !out_valid_q || out_ready;
	end

	// Table memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= {value_q, pos_q};
		end
		if (cmd.scan_rd) begin
			rd_entry_s1 <= mem[scan_addr_q];
		end
	end

	// Word capture and scan index payload.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			value_q   <= v_new;
			last_q    <= last_in;
			comp_q    <= comp_full[VALUE_BITS-1:0];
			comp_ok_q <= comp_ok;
			if (!pair_done_q) begin
				pos_q <= cnt_inc;
			end
		end
		if (cmd.scan_rd) begin
			rd_idx_s1 <= scan_addr_q;
		end
		if (rd_valid_s1 && comp_ok_q && (rd_value == comp_q)) begin
			comp_pos_q <= rd_pos;
		end
		if (rd_valid_s1 && (rd_value == value_q)) begin
			val_idx_q <= rd_idx_s1;
		end
	end

	// Scan control and set state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			hit_comp_q  <= 1'b0;
			hit_val_q   <= 1'b0;
			item_cnt_q  <= '0;
			count_q     <= '0;
			pair_done_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.start) begin
				scan_addr_q <= '0;
				hit_comp_q  <= 1'b0;
				hit_val_q   <= 1'b0;
				if (!pair_done_q) begin
					item_cnt_q <= cnt_inc;
				end
			end else if (cmd.scan_rd) begin
				scan_addr_q <= scan_addr_q + AW'(1);
			end
			if (rd_valid_s1 && comp_ok_q && (rd_value == comp_q)) begin
				hit_comp_q <= 1'b1;
			end
			if (rd_valid_s1 && (rd_value == value_q)) begin
				hit_val_q <= 1'b1;
			end
			if (cmd.commit) begin
				if (!pair_done_q) begin
					if (hit_comp_q) begin
						pair_done_q <= 1'b1;
					end else begin
						ovf_q <= ovf_next;
						if (!hit_val_q && !table_full) begin
							count_q <= count_q + CNTW'(1);
						end
					end
				end
				// The final word of a set clears the set state.
				if (last_q) begin
					item_cnt_q  <= '0;
					count_q     <= '0;
					pair_done_q <= 1'b0;
					ovf_q       <= 1'b0;
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q <= hit_comp_q;
			if (hit_comp_q) begin
				out_first_q  <= first_ext[OUT_POS_BITS-1:0];
				out_second_q <= second_ext[OUT_POS_BITS-1:0];
				out_ovf_q    <= ovf_q;
			end else begin
				out_first_q  <= '0;
				out_second_q <= '0;
				out_ovf_q    <= ovf_next;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_found      = out_found_q;
	assign out_first      = out_first_q;
	assign out_second     = out_second_q;
	assign out_overflowed = out_ovf_q;

endmodule

// ===== design/psms_checker.sv =====
// ----------------------------------------------------------------------------
// Pair sum match search port checker
// Watches the channel ports of the block and flags behavior that breaks it.
// ----------------------------------------------------------------------------
`include "pair_sum_match_search_top_defines.svh"

module psms_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                out_found,
	input logic [psms_pkg::OUT_POS_BITS-1:0]   out_first,
	input logic [psms_pkg::OUT_POS_BITS-1:0]   out_second,
	input logic                                out_ovf
);
	import psms_pkg::*;

	// A stalled result word keeps its contents.
	`PSMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_first) && $stable(out_second) && $stable(out_ovf))

	// A result word only leaves after it was taken.
	`PSMS_ASSERT_SAME(a_out_drop, clk, arst_n, $fell(out_valid), $past(out_ready))

	// A not-found word reports zero positions.
	`PSMS_ASSERT_SAME(a_miss_zero, clk, arst_n, out_valid && !out_found, out_first == '0 && out_second == '0)

	// The block works on one word at a time.
	`PSMS_ASSERT_NEXT(a_one_word, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind pair_sum_match_search_top psms_checker u_psms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_found  (out_ch.found),
	.out_first  (out_ch.first_position),
	.out_second (out_ch.second_position),
	.out_ovf    (out_ch.table_overflowed)
);
